// ===== sv/esp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// esp_pkg
// Shared sizes, derived widths and the hash result struct of the equal-sum
// pair finder.
// ---------------------------------------------------------------------------
package esp_pkg;

  localparam int BUCKETS      = 64;   // 2 .. 4096
  localparam int BUCKET_DEPTH = 8;    // 1 .. 15

  localparam int VAL_W    = 16;
  localparam int SUM_W    = VAL_W + 1;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int FILL_W   = $clog2(BUCKET_DEPTH + 1);
  localparam int ENTRIES  = BUCKETS * BUCKET_DEPTH;
  localparam int ADDR_W   = $clog2(ENTRIES);

  // sum mod BUCKETS by reciprocal: q = (sum * RECIP) >> SUM_W is the true
  // quotient or one below it, so one compare-subtract finishes the remainder.
  localparam int RECIP   = (2 ** SUM_W) / BUCKETS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int BDIV_W  = $clog2(BUCKETS + 1);

  typedef struct packed {
    logic                done;
    logic [SUM_W-1:0]    sum;
    logic [BUCKET_W-1:0] bucket;
  } hash_res_t;

endpackage
`default_nettype wire

// ===== sv/esp_bucket_hash.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// esp_bucket_hash
// Four-stage pipeline: pair sum, then sum mod BUCKETS by reciprocal multiply
// with a single correction step.
// ---------------------------------------------------------------------------
module esp_bucket_hash (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [esp_pkg::VAL_W-1:0] first_value,
  input  wire logic [esp_pkg::VAL_W-1:0] second_value,
  output esp_pkg::hash_res_t             res
);

  localparam int SUM_W    = esp_pkg::SUM_W;
  localparam int RECIP_W  = esp_pkg::RECIP_W;
  localparam int BDIV_W   = esp_pkg::BDIV_W;
  localparam int BUCKET_W = esp_pkg::BUCKET_W;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int QB_W     = SUM_W + BDIV_W;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(esp_pkg::RECIP);
  localparam logic [BDIV_W-1:0]  BDIV_V  = BDIV_W'(esp_pkg::BUCKETS);
  localparam logic [SUM_W-1:0]   BSUM_V  = SUM_W'(esp_pkg::BUCKETS);

  logic [2:0]            vld_r;
  logic                  done_r;
  logic [SUM_W-1:0]      sum0_r, sum1_r, sum2_r, sum3_r;
  logic [PROD_W-1:0]     prod_r;
  logic [QB_W-1:0]       qb_r;
  logic [BUCKET_W-1:0]   bucket_r;

  logic [RECIP_W-1:0] quot;
  logic [SUM_W-1:0]   rem_raw;
  logic [SUM_W-1:0]   rem_fix;

  // quotient estimate: (sum * RECIP) >> SUM_W
  assign quot    = prod_r[PROD_W-1:SUM_W];
  assign rem_raw = sum2_r - qb_r[SUM_W-1:0];
  assign rem_fix = (rem_raw >= BSUM_V) ? rem_raw - BSUM_V : rem_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      done_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[1:0], start};
      done_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    sum0_r   <= SUM_W'(first_value) + SUM_W'(second_value);
    prod_r   <= PROD_W'(sum0_r) * PROD_W'(RECIP_V);
    sum1_r   <= sum0_r;
    qb_r     <= QB_W'(quot) * QB_W'(BDIV_V);
    sum2_r   <= sum1_r;
    bucket_r <= rem_fix[BUCKET_W-1:0];
    sum3_r   <= sum2_r;
  end

  assign res.done   = done_r;
  assign res.sum    = sum3_r;
  assign res.bucket = bucket_r;

endmodule
`default_nettype wire

// ===== sv/equal_sum_pair_finder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// equal_sum_pair_finder
// Chained hash table that finds an earlier stored pair with the same sum and
// no shared value; stores the new pair when no such pair exists and its bucket has room.
// ---------------------------------------------------------------------------
// One pair per transfer, one result per pair. The pair is hashed by its
// 17-bit sum modulo BUCKETS, the bucket fill count is read from the fill
// memory, then the bucket's stored pairs are read from the pair memory
// oldest first, one entry per cycle, up to the fill count. A match ends the
// scan early. Without a match the pair is appended, or dropped with
// bucket_overflow when the bucket is full. No new pair is taken until the
// result of the last one is registered; the next input transfer can be
// taken in the cycle after that.
// One result may wait in the output register while the next pair is
// accepted. After reset the fill memory is cleared one bucket per cycle, so
// in_ready stays low until every bucket has been cleared.
// ---------------------------------------------------------------------------
module equal_sum_pair_finder (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [esp_pkg::VAL_W-1:0] in_first_value,
  input  wire logic [esp_pkg::VAL_W-1:0] in_second_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_match_found,
  output logic [esp_pkg::VAL_W-1:0]      out_match_first,
  output logic [esp_pkg::VAL_W-1:0]      out_match_second,
  output logic                           out_bucket_overflow
);

  localparam int VAL_W    = esp_pkg::VAL_W;
  localparam int SUM_W    = esp_pkg::SUM_W;
  localparam int BUCKET_W = esp_pkg::BUCKET_W;
  localparam int FILL_W   = esp_pkg::FILL_W;
  localparam int ADDR_W   = esp_pkg::ADDR_W;

  localparam logic [FILL_W-1:0]   DEPTH_F  = FILL_W'(esp_pkg::BUCKET_DEPTH);
  localparam logic [ADDR_W-1:0]   DEPTH_A  = ADDR_W'(esp_pkg::BUCKET_DEPTH);
  localparam logic [BUCKET_W-1:0] LAST_BKT = BUCKET_W'(esp_pkg::BUCKETS - 1);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_HASH   = 7'b0000100,
    S_FILL   = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  // Memories. Pair word: first value low, second value high.
  logic [2*VAL_W-1:0] pair_mem [esp_pkg::ENTRIES];
  logic [FILL_W-1:0]  fill_mem [esp_pkg::BUCKETS];

  // Control state
  state_t              state_r, state_nxt;
  logic [BUCKET_W-1:0] clr_r, clr_nxt;
  logic [FILL_W-1:0]   chk_r, chk_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Item payload
  logic [VAL_W-1:0]    a_r, a_nxt;
  logic [VAL_W-1:0]    b_r, b_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [BUCKET_W-1:0] bucket_r, bucket_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                res_found_r, res_found_nxt;
  logic [VAL_W-1:0]    res_first_r, res_first_nxt;
  logic [VAL_W-1:0]    res_second_r, res_second_nxt;
  logic                res_ovf_r, res_ovf_nxt;

  // Output register
  logic                out_found_r, out_found_nxt;
  logic [VAL_W-1:0]    out_first_r, out_first_nxt;
  logic [VAL_W-1:0]    out_second_r, out_second_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // Memory ports
  logic                pm_re, pm_we;
  logic [ADDR_W-1:0]   pm_raddr, pm_waddr;
  logic [2*VAL_W-1:0]  pm_wdata, pm_rdata_r;
  logic                fm_re, fm_we;
  logic [BUCKET_W-1:0] fm_raddr, fm_waddr;
  logic [FILL_W-1:0]   fm_wdata, fm_rdata_r;

  esp_pkg::hash_res_t  hash;
  logic                in_xfer;

  // Scan compare on the entry read last cycle
  logic [VAL_W-1:0]    sa, sb;
  logic                hit;
  logic [FILL_W-1:0]   chk_inc;

  assign in_xfer = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  esp_bucket_hash u_hash (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_xfer),
    .first_value  (in_first_value),
    .second_value (in_second_value),
    .res          (hash)
  );

  assign sa      = pm_rdata_r[VAL_W-1:0];
  assign sb      = pm_rdata_r[2*VAL_W-1:VAL_W];
  assign hit     = ((SUM_W'(sa) + SUM_W'(sb)) == sum_r) &&
                   (sa != a_r) && (sa != b_r) && (sb != a_r) && (sb != b_r);
  assign chk_inc = chk_r + FILL_W'(1);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    chk_nxt        = chk_r;
    out_valid_nxt  = out_valid_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    sum_nxt        = sum_r;
    bucket_nxt     = bucket_r;
    base_nxt       = base_r;
    fill_nxt       = fill_r;
    res_found_nxt  = res_found_r;
    res_first_nxt  = res_first_r;
    res_second_nxt = res_second_r;
    res_ovf_nxt    = res_ovf_r;
    out_found_nxt  = out_found_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_ovf_nxt    = out_ovf_r;

    pm_re    = 1'b0;
    pm_raddr = base_r;
    pm_we    = 1'b0;
    pm_waddr = base_r + ADDR_W'(fill_r);
    pm_wdata = {b_r, a_r};
    fm_re    = 1'b0;
    fm_raddr = bucket_r;
    fm_we    = 1'b0;
    fm_waddr = bucket_r;
    fm_wdata = fill_r + FILL_W'(1);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        fm_we    = 1'b1;
        fm_waddr = clr_r;
        fm_wdata = '0;
        clr_nxt  = clr_r + BUCKET_W'(1);
        if (clr_r == LAST_BKT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          a_nxt     = in_first_value;
          b_nxt     = in_second_value;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        // fill count read issued as the bucket arrives
        if (hash.done) begin
          sum_nxt    = hash.sum;
          bucket_nxt = hash.bucket;
          base_nxt   = ADDR_W'(hash.bucket) * DEPTH_A;
          fm_re      = 1'b1;
          fm_raddr   = hash.bucket;
          state_nxt  = S_FILL;
        end
      end
      S_FILL: begin
        fill_nxt      = (fm_rdata_r > DEPTH_F) ? DEPTH_F : fm_rdata_r;
        chk_nxt       = '0;
        res_found_nxt = 1'b0;
        res_first_nxt = '0;
        res_second_nxt = '0;
        res_ovf_nxt   = 1'b0;
        pm_re         = 1'b1;
        pm_raddr      = base_r;
        state_nxt     = (fm_rdata_r == '0) ? S_DECIDE : S_SCAN;
      end
      S_SCAN: begin
        // entry chk_r is on the read port; prefetch chk_r + 1
        if (hit) begin
          res_found_nxt  = 1'b1;
          res_first_nxt  = sa;
          res_second_nxt = sb;
          state_nxt      = S_DONE;
        end else if (chk_inc >= fill_r) begin
          state_nxt = S_DECIDE;
        end else begin
          pm_re    = 1'b1;
          pm_raddr = base_r + ADDR_W'(chk_inc);
          chk_nxt  = chk_inc;
        end
      end
      S_DECIDE: begin
        // writes land before the next item's reads: no overlap to forward
        if (fill_r < DEPTH_F) begin
          pm_we = 1'b1;
          fm_we = 1'b1;
        end else begin
          res_ovf_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_first_nxt  = res_first_r;
          out_second_nxt = res_second_r;
          out_ovf_nxt    = res_ovf_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      chk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    sum_r        <= sum_nxt;
    bucket_r     <= bucket_nxt;
    base_r       <= base_nxt;
    fill_r       <= fill_nxt;
    res_found_r  <= res_found_nxt;
    res_first_r  <= res_first_nxt;
    res_second_r <= res_second_nxt;
    res_ovf_r    <= res_ovf_nxt;
    out_found_r  <= out_found_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  // Pair memory: one read, one write port, registered read data
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pair_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rdata_r <= pair_mem[pm_raddr];
    end
  end

  // Fill count memory
  always_ff @(posedge clk) begin
    if (fm_we) begin
      fill_mem[fm_waddr] <= fm_wdata;
    end
    if (fm_re) begin
      fm_rdata_r <= fill_mem[fm_raddr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_match_found     = out_found_r;
  assign out_match_first     = out_first_r;
  assign out_match_second    = out_second_r;
  assign out_bucket_overflow = out_ovf_r;

endmodule
`default_nettype wire
